// File: hw/rtl/lli_pkg.sv
package lli_pkg;

  localparam int COORD_WIDTH_DEF = 32;
  localparam int FRAC_BITS_DEF   = 16;

  localparam int                  THR_WIDTH = 40;
  localparam logic [THR_WIDTH-1:0] THR_RESET = 40'd4295;

endpackage

// File: hw/rtl/lli_div.sv
module lli_div #(
  parameter int NW = 81,
  parameter int DW = 64,
  parameter int QW = 50,
  parameter int PW = 135
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          en,
  input  logic          in_valid,
  input  logic [NW-1:0] in_num_a,
  input  logic [NW-1:0] in_num_b,
  input  logic [DW-1:0] in_den,
  input  logic [PW-1:0] in_pay,
  output logic          out_valid,
  output logic [QW-1:0] out_quo_a,
  output logic [QW-1:0] out_quo_b,
  output logic          out_ovf_a,
  output logic          out_ovf_b,
  output logic [PW-1:0] out_pay
);

  localparam int CW = DW + QW + 1;

  logic          vld_r   [0:QW];
  logic [NW-1:0] rem_a_r [0:QW];
  logic [NW-1:0] rem_b_r [0:QW];
  logic [QW-1:0] quo_a_r [0:QW];
  logic [QW-1:0] quo_b_r [0:QW];
  logic          ovf_a_r [0:QW];
  logic          ovf_b_r [0:QW];
  logic [DW-1:0] den_r   [0:QW];
  logic [PW-1:0] pay_r   [0:QW];

  // Entry stage: flag quotients that do not fit in QW bits.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r[0] <= 1'b0;
    end else if (en) begin
      vld_r[0] <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_a_r[0] <= in_num_a;
      rem_b_r[0] <= in_num_b;
      quo_a_r[0] <= '0;
      quo_b_r[0] <= '0;
      ovf_a_r[0] <= CW'(in_num_a) >= (CW'(in_den) << QW);
      ovf_b_r[0] <= CW'(in_num_b) >= (CW'(in_den) << QW);
      den_r[0]   <= in_den;
      pay_r[0]   <= in_pay;
    end
  end

  // One quotient bit per stage, most significant first.
  for (genvar k = 1; k <= QW; k++) begin : g_stage
    localparam int BIT = QW - k;
    logic [CW-1:0] dsh;
    logic          ge_a;
    logic          ge_b;
    logic [NW-1:0] rem_a_nxt;
    logic [NW-1:0] rem_b_nxt;

    assign dsh       = CW'(den_r[k-1]) << BIT;
    assign ge_a      = CW'(rem_a_r[k-1]) >= dsh;
    assign ge_b      = CW'(rem_b_r[k-1]) >= dsh;
    assign rem_a_nxt = ge_a ? NW'(CW'(rem_a_r[k-1]) - dsh) : rem_a_r[k-1];
    assign rem_b_nxt = ge_b ? NW'(CW'(rem_b_r[k-1]) - dsh) : rem_b_r[k-1];

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k] <= 1'b0;
      end else if (en) begin
        vld_r[k] <= vld_r[k-1];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_a_r[k] <= rem_a_nxt;
        rem_b_r[k] <= rem_b_nxt;
        quo_a_r[k] <= quo_a_r[k-1] | (QW'(ge_a) << BIT);
        quo_b_r[k] <= quo_b_r[k-1] | (QW'(ge_b) << BIT);
        ovf_a_r[k] <= ovf_a_r[k-1];
        ovf_b_r[k] <= ovf_b_r[k-1];
        den_r[k]   <= den_r[k-1];
        pay_r[k]   <= pay_r[k-1];
      end
    end
  end

  assign out_valid = vld_r[QW];
  assign out_quo_a = quo_a_r[QW];
  assign out_quo_b = quo_b_r[QW];
  assign out_ovf_a = ovf_a_r[QW];
  assign out_ovf_b = ovf_b_r[QW];
  assign out_pay   = pay_r[QW];

endmodule

// File: hw/rtl/line_line_intersection.sv
// Intersection of two 2D lines given as origin and direction in signed fixed point
// (Q16.16 by default). One line pair is accepted per clock; the result passes through
// the input stages, the bit-per-stage divider pipeline that forms both line
// parameters, the point stages and the output register. A stalled output holds the
// whole pipeline. Lines whose direction cross product is zero or below cfg_data
// (Q32.32 magnitude) give hit_valid low and all other fields zero.
module line_line_intersection #(
  parameter int COORD_WIDTH = lli_pkg::COORD_WIDTH_DEF,
  parameter int FRAC_BITS   = lli_pkg::FRAC_BITS_DEF
) (
  input  logic                                    clk,
  input  logic                                    rst_n,
  input  logic                                    in_tvalid,
  output logic                                    in_tready,
  // origin_a_x, origin_a_y, dir_a_x, dir_a_y, origin_b_x, origin_b_y, dir_b_x, dir_b_y
  input  logic [8*COORD_WIDTH-1:0]                in_tdata,
  output logic                                    out_tvalid,
  input  logic                                    out_tready,
  // point_x, point_y, param_a, param_b, zero fill
  output logic [((4*COORD_WIDTH+7)/8)*8-1:0]      out_tdata,
  // hit_valid, saturated
  output logic [1:0]                              out_tuser,
  input  logic                                    cfg_valid,
  output logic                                    cfg_ready,
  input  logic [lli_pkg::THR_WIDTH-1:0]           cfg_data
);

  import lli_pkg::*;

  localparam int W   = COORD_WIDTH;
  localparam int F   = FRAC_BITS;
  localparam int OTW = ((4*W+7)/8)*8;
  localparam int DW  = 2*W;
  localparam int NW  = 2*W + 1 + F;
  localparam int QW  = W + F + 2;
  localparam int SW  = QW + W;
  localparam int VW  = SW + 2 - F;
  localparam int PW  = 4*W + 7;

  localparam logic [W-1:0]  CMAX = {1'b0, {(W-1){1'b1}}};
  localparam logic [W-1:0]  CMIN = {1'b1, {(W-1){1'b0}}};
  localparam logic [QW-1:0] QLIM = QW'(1) << (W-1);

  logic en;
  logic out_valid_r;
  logic [THR_WIDTH-1:0] thr_r;

  assign en        = !out_valid_r || out_tready;
  assign in_tready = en;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r <= THR_RESET;
    end else if (cfg_valid) begin
      thr_r <= cfg_data;
    end
  end

  // ---------------- stage 1: deltas and direction products
  logic signed [W-1:0] in_oax, in_oay, in_dax, in_day, in_obx, in_oby, in_dbx, in_dby;
  assign in_oax = in_tdata[0*W +: W];
  assign in_oay = in_tdata[1*W +: W];
  assign in_dax = in_tdata[2*W +: W];
  assign in_day = in_tdata[3*W +: W];
  assign in_obx = in_tdata[4*W +: W];
  assign in_oby = in_tdata[5*W +: W];
  assign in_dbx = in_tdata[6*W +: W];
  assign in_dby = in_tdata[7*W +: W];

  logic                  s1_vld_r;
  logic signed [W-1:0]   s1_oax_r, s1_oay_r, s1_dax_r, s1_day_r, s1_dbx_r, s1_dby_r;
  logic signed [W:0]     s1_dx_r, s1_dy_r;
  logic signed [2*W-1:0] s1_pd1_r, s1_pd2_r;
  logic signed [W:0]     s1_dx_nxt, s1_dy_nxt;
  logic signed [2*W-1:0] s1_pd1_nxt, s1_pd2_nxt;

  assign s1_dx_nxt  = (W+1)'(in_obx) - (W+1)'(in_oax);
  assign s1_dy_nxt  = (W+1)'(in_oby) - (W+1)'(in_oay);
  assign s1_pd1_nxt = in_dax * in_dby;
  assign s1_pd2_nxt = in_day * in_dbx;

  // ---------------- stage 2: denominator and numerator products
  logic                  s2_vld_r;
  logic signed [W-1:0]   s2_oax_r, s2_oay_r, s2_dax_r, s2_day_r;
  logic signed [2*W:0]   s2_den_r, s2_pn1_r, s2_pn2_r, s2_pn3_r, s2_pn4_r;
  logic signed [2*W:0]   s2_den_nxt, s2_pn1_nxt, s2_pn2_nxt, s2_pn3_nxt, s2_pn4_nxt;

  assign s2_den_nxt = s1_pd1_r - s1_pd2_r;
  assign s2_pn1_nxt = s1_dx_r * s1_dby_r;
  assign s2_pn2_nxt = s1_dy_r * s1_dbx_r;
  assign s2_pn3_nxt = s1_dx_r * s1_day_r;
  assign s2_pn4_nxt = s1_dy_r * s1_dax_r;

  // ---------------- stage 3: numerators, denominator magnitude
  logic                  s3_vld_r;
  logic signed [W-1:0]   s3_oax_r, s3_oay_r, s3_dax_r, s3_day_r;
  logic signed [2*W+1:0] s3_na_r, s3_nb_r;
  logic [DW-1:0]         s3_dmag_r;
  logic                  s3_dneg_r;
  logic signed [2*W+1:0] s3_na_nxt, s3_nb_nxt;
  logic [DW-1:0]         s3_dmag_nxt;

  assign s3_na_nxt   = (2*W+2)'(s2_pn1_r) - (2*W+2)'(s2_pn2_r);
  assign s3_nb_nxt   = (2*W+2)'(s2_pn3_r) - (2*W+2)'(s2_pn4_r);
  assign s3_dmag_nxt = s2_den_r[2*W] ? DW'(-s2_den_r) : DW'(s2_den_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
      s2_vld_r <= 1'b0;
      s3_vld_r <= 1'b0;
    end else if (en) begin
      s1_vld_r <= in_tvalid;
      s2_vld_r <= s1_vld_r;
      s3_vld_r <= s2_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_oax_r  <= in_oax;
      s1_oay_r  <= in_oay;
      s1_dax_r  <= in_dax;
      s1_day_r  <= in_day;
      s1_dbx_r  <= in_dbx;
      s1_dby_r  <= in_dby;
      s1_dx_r   <= s1_dx_nxt;
      s1_dy_r   <= s1_dy_nxt;
      s1_pd1_r  <= s1_pd1_nxt;
      s1_pd2_r  <= s1_pd2_nxt;
      s2_oax_r  <= s1_oax_r;
      s2_oay_r  <= s1_oay_r;
      s2_dax_r  <= s1_dax_r;
      s2_day_r  <= s1_day_r;
      s2_den_r  <= s2_den_nxt;
      s2_pn1_r  <= s2_pn1_nxt;
      s2_pn2_r  <= s2_pn2_nxt;
      s2_pn3_r  <= s2_pn3_nxt;
      s2_pn4_r  <= s2_pn4_nxt;
      s3_oax_r  <= s2_oax_r;
      s3_oay_r  <= s2_oay_r;
      s3_dax_r  <= s2_dax_r;
      s3_day_r  <= s2_day_r;
      s3_na_r   <= s3_na_nxt;
      s3_nb_r   <= s3_nb_nxt;
      s3_dmag_r <= s3_dmag_nxt;
      s3_dneg_r <= s2_den_r[2*W];
    end
  end

  // ---------------- divider entry: magnitudes, signs, parallel test
  logic signed [2*W+1:0] na_mag, nb_mag;
  logic [NW-1:0]         div_num_a, div_num_b;
  logic [W-1:0]          daxm, daym;
  logic                  par;
  logic [PW-1:0]         div_pay;

  assign na_mag    = s3_na_r[2*W+1] ? -s3_na_r : s3_na_r;
  assign nb_mag    = s3_nb_r[2*W+1] ? -s3_nb_r : s3_nb_r;
  assign div_num_a = {na_mag[2*W:0], {F{1'b0}}};
  assign div_num_b = {nb_mag[2*W:0], {F{1'b0}}};
  assign daxm      = s3_dax_r[W-1] ? W'(-s3_dax_r) : W'(s3_dax_r);
  assign daym      = s3_day_r[W-1] ? W'(-s3_day_r) : W'(s3_day_r);
  assign par       = (s3_dmag_r == '0) ||
                     ((DW+THR_WIDTH)'(s3_dmag_r) < (DW+THR_WIDTH)'(thr_r));
  assign div_pay   = {par,
                      s3_nb_r[2*W+1] ^ s3_dneg_r,
                      s3_na_r[2*W+1] ^ s3_dneg_r,
                      s3_day_r == '0, s3_dax_r == '0,
                      s3_day_r[W-1], s3_dax_r[W-1],
                      daym, daxm, s3_oay_r, s3_oax_r};

  logic          dv_vld;
  logic [QW-1:0] dv_qa, dv_qb;
  logic          dv_ova, dv_ovb;
  logic [PW-1:0] dv_pay;

  lli_div #(
    .NW(NW),
    .DW(DW),
    .QW(QW),
    .PW(PW)
  ) u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (s3_vld_r),
    .in_num_a  (div_num_a),
    .in_num_b  (div_num_b),
    .in_den    (s3_dmag_r),
    .in_pay    (div_pay),
    .out_valid (dv_vld),
    .out_quo_a (dv_qa),
    .out_quo_b (dv_qb),
    .out_ovf_a (dv_ova),
    .out_ovf_b (dv_ovb),
    .out_pay   (dv_pay)
  );

  logic [W-1:0] dv_oax, dv_oay, dv_daxm, dv_daym;
  logic         dv_axneg, dv_ayneg, dv_axz, dv_ayz, dv_ta, dv_tb, dv_par;

  assign {dv_par, dv_tb, dv_ta, dv_ayz, dv_axz, dv_ayneg, dv_axneg,
          dv_daym, dv_daxm, dv_oay, dv_oax} = dv_pay;

  // ---------------- P1: parameter saturation, partial products of t*dir
  logic         pa_clip, pb_clip;
  logic [W-1:0] pa_val, pb_val;

  assign pa_clip = dv_ova || (dv_ta ? (dv_qa > QLIM) : (dv_qa >= QLIM));
  assign pb_clip = dv_ovb || (dv_tb ? (dv_qb > QLIM) : (dv_qb >= QLIM));
  assign pa_val  = pa_clip ? (dv_ta ? CMIN : CMAX)
                           : (dv_ta ? W'(-dv_qa[W-1:0]) : dv_qa[W-1:0]);
  assign pb_val  = pb_clip ? (dv_tb ? CMIN : CMAX)
                           : (dv_tb ? W'(-dv_qb[W-1:0]) : dv_qb[W-1:0]);

  logic            p1_vld_r;
  logic [2*W-1:0]  p1_xl_r, p1_yl_r;
  logic [QW-1:0]   p1_xh_r, p1_yh_r;
  logic            p1_huge_r, p1_ta_r, p1_axneg_r, p1_ayneg_r, p1_axz_r, p1_ayz_r;
  logic            p1_par_r, p1_pclip_r;
  logic [W-1:0]    p1_oax_r, p1_oay_r, p1_pa_r, p1_pb_r;
  logic [2*W-1:0]  p1_xl_nxt, p1_yl_nxt;
  logic [QW-1:0]   p1_xh_nxt, p1_yh_nxt;

  assign p1_xl_nxt = dv_qa[W-1:0] * dv_daxm;
  assign p1_yl_nxt = dv_qa[W-1:0] * dv_daym;
  assign p1_xh_nxt = QW'(dv_qa[QW-1:W]) * QW'(dv_daxm);
  assign p1_yh_nxt = QW'(dv_qa[QW-1:W]) * QW'(dv_daym);

  // ---------------- P2: full product magnitude
  logic          p2_vld_r;
  logic [SW-1:0] p2_sx_r, p2_sy_r;
  logic          p2_negx_r, p2_negy_r, p2_huge_r, p2_axz_r, p2_ayz_r, p2_par_r, p2_pclip_r;
  logic [W-1:0]  p2_oax_r, p2_oay_r, p2_pa_r, p2_pb_r;
  logic [SW-1:0] p2_sx_nxt, p2_sy_nxt;

  assign p2_sx_nxt = SW'(p1_xl_r) + (SW'(p1_xh_r) << W);
  assign p2_sy_nxt = SW'(p1_yl_r) + (SW'(p1_yh_r) << W);

  // ---------------- P3: apply sign
  logic              p3_vld_r;
  logic signed [SW:0] p3_px_r, p3_py_r;
  logic              p3_negx_r, p3_negy_r, p3_huge_r, p3_axz_r, p3_ayz_r, p3_par_r, p3_pclip_r;
  logic [W-1:0]      p3_oax_r, p3_oay_r, p3_pa_r, p3_pb_r;
  logic signed [SW:0] sx_ext, sy_ext, p3_px_nxt, p3_py_nxt;

  assign sx_ext    = {1'b0, p2_sx_r};
  assign sy_ext    = {1'b0, p2_sy_r};
  assign p3_px_nxt = p2_negx_r ? -sx_ext : sx_ext;
  assign p3_py_nxt = p2_negy_r ? -sy_ext : sy_ext;

  // ---------------- P4: floor shift and add origin
  logic               p4_vld_r;
  logic signed [VW-1:0] p4_vx_r, p4_vy_r;
  logic               p4_negx_r, p4_negy_r, p4_huge_r, p4_axz_r, p4_ayz_r, p4_par_r, p4_pclip_r;
  logic [W-1:0]       p4_oax_r, p4_oay_r, p4_pa_r, p4_pb_r;
  logic signed [VW-1:0] p4_vx_nxt, p4_vy_nxt;
  logic signed [W-1:0]  p3_oax_s, p3_oay_s;
  logic signed [SW:0]   p3_px_sh, p3_py_sh;

  assign p3_oax_s  = p3_oax_r;
  assign p3_oay_s  = p3_oay_r;
  assign p3_px_sh  = p3_px_r >>> F;
  assign p3_py_sh  = p3_py_r >>> F;
  assign p4_vx_nxt = VW'(p3_oax_s) + VW'(p3_px_sh);
  assign p4_vy_nxt = VW'(p3_oay_s) + VW'(p3_py_sh);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p1_vld_r <= 1'b0;
      p2_vld_r <= 1'b0;
      p3_vld_r <= 1'b0;
      p4_vld_r <= 1'b0;
    end else if (en) begin
      p1_vld_r <= dv_vld;
      p2_vld_r <= p1_vld_r;
      p3_vld_r <= p2_vld_r;
      p4_vld_r <= p3_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p1_xl_r    <= p1_xl_nxt;
      p1_yl_r    <= p1_yl_nxt;
      p1_xh_r    <= p1_xh_nxt;
      p1_yh_r    <= p1_yh_nxt;
      p1_huge_r  <= dv_ova || dv_qa[QW-1];
      p1_ta_r    <= dv_ta;
      p1_axneg_r <= dv_axneg;
      p1_ayneg_r <= dv_ayneg;
      p1_axz_r   <= dv_axz;
      p1_ayz_r   <= dv_ayz;
      p1_par_r   <= dv_par;
      p1_pclip_r <= pa_clip || pb_clip;
      p1_oax_r   <= dv_oax;
      p1_oay_r   <= dv_oay;
      p1_pa_r    <= pa_val;
      p1_pb_r    <= pb_val;

      p2_sx_r    <= p2_sx_nxt;
      p2_sy_r    <= p2_sy_nxt;
      p2_negx_r  <= p1_ta_r ^ p1_axneg_r;
      p2_negy_r  <= p1_ta_r ^ p1_ayneg_r;
      p2_huge_r  <= p1_huge_r;
      p2_axz_r   <= p1_axz_r;
      p2_ayz_r   <= p1_ayz_r;
      p2_par_r   <= p1_par_r;
      p2_pclip_r <= p1_pclip_r;
      p2_oax_r   <= p1_oax_r;
      p2_oay_r   <= p1_oay_r;
      p2_pa_r    <= p1_pa_r;
      p2_pb_r    <= p1_pb_r;

      p3_px_r    <= p3_px_nxt;
      p3_py_r    <= p3_py_nxt;
      p3_negx_r  <= p2_negx_r;
      p3_negy_r  <= p2_negy_r;
      p3_huge_r  <= p2_huge_r;
      p3_axz_r   <= p2_axz_r;
      p3_ayz_r   <= p2_ayz_r;
      p3_par_r   <= p2_par_r;
      p3_pclip_r <= p2_pclip_r;
      p3_oax_r   <= p2_oax_r;
      p3_oay_r   <= p2_oay_r;
      p3_pa_r    <= p2_pa_r;
      p3_pb_r    <= p2_pb_r;

      p4_vx_r    <= p4_vx_nxt;
      p4_vy_r    <= p4_vy_nxt;
      p4_negx_r  <= p3_negx_r;
      p4_negy_r  <= p3_negy_r;
      p4_huge_r  <= p3_huge_r;
      p4_axz_r   <= p3_axz_r;
      p4_ayz_r   <= p3_ayz_r;
      p4_par_r   <= p3_par_r;
      p4_pclip_r <= p3_pclip_r;
      p4_oax_r   <= p3_oax_r;
      p4_oay_r   <= p3_oay_r;
      p4_pa_r    <= p3_pa_r;
      p4_pb_r    <= p3_pb_r;
    end
  end

  // ---------------- output: point saturation and result register
  logic         fit_x, fit_y, clip_x, clip_y;
  logic [W-1:0] pt_x, pt_y;

  assign fit_x  = (&p4_vx_r[VW-1:W-1]) || !(|p4_vx_r[VW-1:W-1]);
  assign fit_y  = (&p4_vy_r[VW-1:W-1]) || !(|p4_vy_r[VW-1:W-1]);
  assign clip_x = !p4_axz_r && (p4_huge_r || !fit_x);
  assign clip_y = !p4_ayz_r && (p4_huge_r || !fit_y);

  always_comb begin
    if (p4_axz_r) begin
      pt_x = p4_oax_r;
    end else if (p4_huge_r) begin
      pt_x = p4_negx_r ? CMIN : CMAX;
    end else if (fit_x) begin
      pt_x = p4_vx_r[W-1:0];
    end else begin
      pt_x = p4_vx_r[VW-1] ? CMIN : CMAX;
    end
    if (p4_ayz_r) begin
      pt_y = p4_oay_r;
    end else if (p4_huge_r) begin
      pt_y = p4_negy_r ? CMIN : CMAX;
    end else if (fit_y) begin
      pt_y = p4_vy_r[W-1:0];
    end else begin
      pt_y = p4_vy_r[VW-1] ? CMIN : CMAX;
    end
  end

  logic [OTW-1:0]   out_tdata_r;
  logic [1:0]       out_tuser_r;
  logic [OTW-1:0]   out_tdata_nxt;
  logic [1:0]       out_tuser_nxt;

  // Parallel lines report nothing but a cleared hit flag.
  assign out_tdata_nxt = p4_par_r ? '0 : OTW'({p4_pb_r, p4_pa_r, pt_y, pt_x});
  assign out_tuser_nxt = p4_par_r ? 2'b00
                                  : {p4_pclip_r || clip_x || clip_y, 1'b1};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= p4_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_tdata_r <= out_tdata_nxt;
      out_tuser_r <= out_tuser_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_tdata_r;
  assign out_tuser  = out_tuser_r;

endmodule

// File: tb/line_line_intersection_tb.sv
module line_line_intersection_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CW = lli_pkg::COORD_WIDTH_DEF;
  localparam int FB = lli_pkg::FRAC_BITS_DEF;
  localparam int LATENCY = CW + FB + 11;
  localparam int CYCLE_LIMIT = 400000;
  localparam int RX_HOLD_CYCLES = 400;

  typedef logic signed [127:0] wide_t;

  typedef struct packed {
    logic        hit;
    logic        sat;
    logic [31:0] px;
    logic [31:0] py;
    logic [31:0] pa;
    logic [31:0] pb;
  } hit_rec_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [255:0] in_tdata = '0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [127:0] out_tdata;
  logic [1:0] out_tuser;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [lli_pkg::THR_WIDTH-1:0] cfg_data = '0;

  logic [255:0] line_pair_q[$];
  hit_rec_t hit_expect_q[$];
  logic [39:0] thr_cur = lli_pkg::THR_RESET;
  int error_cnt = 0;
  int cycle_cnt = 0;
  int idle_pct = 25;
  bit in_taken = 0;
  bit rx_hold_go = 0;
  int rx_hold_cnt = 0;

  line_line_intersection DUT (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready),
    .out_tdata(out_tdata), .out_tuser(out_tuser),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic logic [31:0] sat_coord(wide_t v, inout logic clip);
    if (v > wide_t'(32'sh7fffffff)) begin
      clip = 1'b1;
      return 32'h7fffffff;
    end
    if (v < -wide_t'(33'sh080000000)) begin
      clip = 1'b1;
      return 32'h80000000;
    end
    return v[31:0];
  endfunction

  function automatic logic [31:0] point_comp(wide_t org, wide_t dir, wide_t t, inout logic clip);
    wide_t mag;
    mag = (t < 0) ? -t : t;
    if (dir == 0) return org[31:0];
    if (mag >= (wide_t'(1) <<< (CW + FB + 1))) begin
      clip = 1'b1;
      return ((t < 0) != (dir < 0)) ? 32'h80000000 : 32'h7fffffff;
    end
    return sat_coord(org + ((t * dir) >>> FB), clip);
  endfunction

  function automatic hit_rec_t solve_intersection(logic [255:0] d, logic [39:0] thr);
    wide_t f[8];
    wide_t den, mag, dx, dy, na, nb, t, u;
    hit_rec_t r;
    logic clip;
    for (int i = 0; i < 8; i++) f[i] = wide_t'($signed(d[32*i +: 32]));
    r = '0;
    clip = 1'b0;
    den = f[2] * f[7] - f[3] * f[6];
    mag = (den < 0) ? -den : den;
    if (den == 0 || $unsigned(mag) < {88'b0, thr}) return r;
    dx = f[4] - f[0];
    dy = f[5] - f[1];
    na = dx * f[7] - dy * f[6];
    nb = dx * f[3] - dy * f[2];
    t = (na <<< FB) / den;
    u = (nb <<< FB) / den;
    r.hit = 1'b1;
    r.px = point_comp(f[0], f[2], t, clip);
    r.py = point_comp(f[1], f[3], t, clip);
    r.pa = sat_coord(t, clip);
    r.pb = sat_coord(u, clip);
    r.sat = clip;
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("MISMATCH %s: got %h expected %h at cycle %0d", what, got, want, cycle_cnt);
    error_cnt++;
  endtask

  // drive the next line pair at the falling edge
  always @(negedge clk) begin
    if (!in_tvalid || in_taken) begin
      if (line_pair_q.size() > 0 && $urandom_range(99) >= idle_pct) begin
        in_tdata <= line_pair_q.pop_front();
        in_tvalid <= 1'b1;
      end else begin
        in_tvalid <= 1'b0;
      end
    end
    in_taken = 0;
  end

  always @(negedge clk) begin
    if (rx_hold_cnt > 0) rx_hold_cnt <= rx_hold_cnt - 1;
    else if (rx_hold_go) rx_hold_cnt <= RX_HOLD_CYCLES;
  end

  always @(negedge clk) begin
    out_tready <= (rx_hold_cnt == 0) && !rx_hold_go && ($urandom_range(99) >= idle_pct);
  end

  always @(posedge clk) begin
    hit_rec_t w;
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end else if (rst_n) begin
      if (in_tvalid && in_tready) begin
        hit_expect_q.push_back(solve_intersection(in_tdata, thr_cur));
        in_taken = 1;
      end
      if (out_tvalid && out_tready) begin
        if (hit_expect_q.size() == 0) begin
          report_mismatch("unexpected result", out_tdata[31:0], 32'h0);
        end else begin
          w = hit_expect_q.pop_front();
          if (out_tuser[0] !== w.hit) report_mismatch("hit_valid", 32'(out_tuser[0]),
                                                      32'(w.hit));
          if (out_tuser[1] !== w.sat) report_mismatch("saturated", 32'(out_tuser[1]),
                                                      32'(w.sat));
          if (out_tdata[31:0] !== w.px) report_mismatch("point_x", out_tdata[31:0], w.px);
          if (out_tdata[63:32] !== w.py) report_mismatch("point_y", out_tdata[63:32], w.py);
          if (out_tdata[95:64] !== w.pa) report_mismatch("param_a", out_tdata[95:64], w.pa);
          if (out_tdata[127:96] !== w.pb) report_mismatch("param_b", out_tdata[127:96], w.pb);
        end
      end
    end
  end

  function automatic logic [31:0] small_coord();
    return 32'($signed($urandom_range(2 * 1048576)) - 1048576);
  endfunction

  function automatic logic [31:0] edge_coord();
    case ($urandom_range(5))
      0: return 32'h80000000;
      1: return 32'h7fffffff;
      2: return 32'h0;
      3: return 32'hffffffff;
      4: return 32'h00010000;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [255:0] pack_pair(logic [31:0] oax, oay, dax, day,
                                             logic [31:0] obx, oby, dbx, dby);
    return {dby, dbx, oby, obx, day, dax, oay, oax};
  endfunction

  function automatic logic [255:0] random_pair();
    logic [31:0] v[8];
    int mode;
    mode = $urandom_range(9);
    for (int i = 0; i < 8; i++) v[i] = (mode < 5) ? small_coord() : $urandom;
    if (mode == 7 || mode == 8) begin
      // nearly parallel: second direction follows the first with a small nudge
      v[6] = v[2] + 32'($signed($urandom_range(8)) - 4);
      v[7] = v[3] + 32'($signed($urandom_range(8)) - 4);
      if ($urandom_range(1)) begin
        v[2] = 32'($signed($urandom_range(8192)) - 4096);
        v[3] = 32'($signed($urandom_range(8192)) - 4096);
        v[6] = v[2] + 32'($signed($urandom_range(2)) - 1);
        v[7] = v[3];
      end
    end else if (mode == 9) begin
      for (int i = 0; i < 8; i++) v[i] = edge_coord();
    end
    return pack_pair(v[0], v[1], v[2], v[3], v[4], v[5], v[6], v[7]);
  endfunction

  task automatic write_threshold(logic [39:0] v);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= v;
    do @(posedge clk); while (!cfg_ready);
    thr_cur = v;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic drain();
    do @(posedge clk);
    while (line_pair_q.size() != 0 || in_tvalid || hit_expect_q.size() != 0);
    repeat (LATENCY + 10) @(posedge clk);
  endtask

  initial begin
    logic [39:0] thr_list[5];
    thr_list = '{40'd0, 40'hff_ffff_ffff, 40'd4295, 40'h1_0000_0000, 40'd65535};
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // parallel, zero, extreme and huge-parameter cases
    line_pair_q.push_back(pack_pair(0, 0, 0, 0, 0, 0, 0, 0));
    line_pair_q.push_back(pack_pair(0, 0, 32'h10000, 0, 32'h10000, 32'h10000, 0, 32'h10000));
    line_pair_q.push_back(pack_pair(0, 0, 32'h10000, 0, 0, 32'h10000, 32'h20000, 0));
    line_pair_q.push_back(pack_pair(0, 0, 1, 0, 0, 0, 1, 1));
    line_pair_q.push_back(pack_pair(0, 0, 32'h10000, 0, 0, 0, 32'h10000, 1));
    line_pair_q.push_back(pack_pair(32'h80000000, 32'h7fffffff, 32'h10000, 1, 32'h7fffffff,
                                    32'h80000000, 1, 32'h10000));
    line_pair_q.push_back(pack_pair(32'h80000000, 32'h80000000, 32'h7fffffff, 32'h80000000,
                                    32'h7fffffff, 32'h7fffffff, 32'h80000000, 32'h7fffffff));
    line_pair_q.push_back(pack_pair(32'h7fffffff, 32'h7fffffff, 32'h80000000, 32'h80000000,
                                    32'h80000000, 32'h80000000, 32'h7fffffff, 32'h80000000));
    line_pair_q.push_back(pack_pair(0, 0, 32'h100, 0, 32'h7fffffff, 32'h7fffffff, 32'h100, 1));
    line_pair_q.push_back(pack_pair(32'h10000, 0, 0, 32'h10000, 0, 32'h30000, 32'h10000, 0));
    line_pair_q.push_back(pack_pair(32'hffff0000, 32'hffff0000, 32'h10000, 32'h10000, 32'h10000,
                                    32'hffff0000, 32'hffff0000, 32'h10000));
    line_pair_q.push_back(pack_pair(0, 0, 32'h7fffffff, 32'h7fffffff, 32'h80000000, 0,
                                    32'h7fffffff, 32'h7ffffffe));
    line_pair_q.push_back(pack_pair(32'hffffffff, 32'hffffffff, 32'hffffffff, 0, 0, 0, 0,
                                    32'hffffffff));
    line_pair_q.push_back(pack_pair(0, 0, 32'h41, 0, 0, 0, 0, 32'h41));
    drain();

    for (int ph = 0; ph < 5; ph++) begin
      write_threshold(thr_list[ph]);
      idle_pct = (ph == 1) ? 0 : 25;
      for (int i = 0; i < 260; i++) line_pair_q.push_back(random_pair());
      if (ph == 2) begin
        // hold the receiver so the pipeline backs up into the input
        @(posedge clk);
        rx_hold_go = 1;
        @(posedge clk);
        rx_hold_go = 0;
      end
      drain();
    end
    write_threshold(40'($urandom_range(32'hffffffff)));
    for (int i = 0; i < 20; i++) line_pair_q.push_back(random_pair());
    drain();

    if (error_cnt == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// File: filelist.f
hw/rtl/lli_pkg.sv
hw/rtl/lli_div.sv
hw/rtl/line_line_intersection.sv
tb/line_line_intersection_tb.sv
